// File: design/tpc_pkg.sv
// shared types, constants and register indexes for the touch point calibration block
// no dependencies; imported by every module of the block
`default_nettype none

package tpc_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int SCREEN_BITS   = 12;
    localparam int POINT_BITS    = 13;
    localparam int PRESSURE_BITS = 12;
    localparam int PROD_BITS     = SAMPLE_BITS + SCREEN_BITS;
    localparam int WIDE_BITS     = SAMPLE_BITS + SCREEN_BITS + 1;
    localparam int ADDR_BITS     = 5;
    localparam int DATA_BITS     = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int LATENCY       = SCREEN_BITS + 3;

    localparam int MODE_CAL_BIT  = 0;
    localparam int MODE_ROT_BIT  = 1;

    localparam logic [SAMPLE_BITS-1:0] THRESH_RESET = SAMPLE_BITS'(10);

    typedef enum logic [2:0] {
        REG_THRESH = 3'd0,
        REG_X_MIN  = 3'd1,
        REG_X_MAX  = 3'd2,
        REG_Y_MIN  = 3'd3,
        REG_Y_MAX  = 3'd4,
        REG_WIDTH  = 3'd5,
        REG_HEIGHT = 3'd6,
        REG_MODE   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] thresh;
        logic [SAMPLE_BITS-1:0] x_min;
        logic [SAMPLE_BITS-1:0] x_max;
        logic [SAMPLE_BITS-1:0] y_min;
        logic [SAMPLE_BITS-1:0] y_max;
        logic [SCREEN_BITS-1:0] width;
        logic [SCREEN_BITS-1:0] height;
        logic [1:0]             mode;
    } cfg_t;

    // one classified sample waiting for the mapping pipeline
    typedef struct packed {
        logic                   touched;
        logic                   calib;
        logic                   rotate;
        logic                   err;
        logic [SAMPLE_BITS-1:0] pressure;
        logic [SAMPLE_BITS-1:0] raw_x;
        logic [SAMPLE_BITS-1:0] raw_y;
        logic [SAMPLE_BITS-1:0] off_x;
        logic [SAMPLE_BITS-1:0] off_y;
        logic [SAMPLE_BITS-1:0] span_x;
        logic [SAMPLE_BITS-1:0] span_y;
    } item_t;

endpackage

`default_nettype wire

// File: design/tpc_regs.sv
// configuration register file behind the apb-style port
// depends on tpc_pkg
`default_nettype none

module tpc_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tpc_pkg::ADDR_BITS-1:0]  paddr,
    input  wire logic [tpc_pkg::DATA_BITS-1:0]  pwdata,
    output logic      [tpc_pkg::DATA_BITS-1:0]  prdata,
    output tpc_pkg::cfg_t                       cfg
);
    import tpc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_THRESH: cfg_next.thresh = pwdata[SAMPLE_BITS-1:0];
                REG_X_MIN:  cfg_next.x_min  = pwdata[SAMPLE_BITS-1:0];
                REG_X_MAX:  cfg_next.x_max  = pwdata[SAMPLE_BITS-1:0];
                REG_Y_MIN:  cfg_next.y_min  = pwdata[SAMPLE_BITS-1:0];
                REG_Y_MAX:  cfg_next.y_max  = pwdata[SAMPLE_BITS-1:0];
                REG_WIDTH:  cfg_next.width  = pwdata[SCREEN_BITS-1:0];
                REG_HEIGHT: cfg_next.height = pwdata[SCREEN_BITS-1:0];
                REG_MODE:   cfg_next.mode   = pwdata[1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thresh <= THRESH_RESET;
            cfg_reg.x_min  <= '0;
            cfg_reg.x_max  <= '1;
            cfg_reg.y_min  <= '0;
            cfg_reg.y_max  <= '1;
            cfg_reg.width  <= '0;
            cfg_reg.height <= '0;
            cfg_reg.mode   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_THRESH: prdata = DATA_BITS'(cfg_reg.thresh);
            REG_X_MIN:  prdata = DATA_BITS'(cfg_reg.x_min);
            REG_X_MAX:  prdata = DATA_BITS'(cfg_reg.x_max);
            REG_Y_MIN:  prdata = DATA_BITS'(cfg_reg.y_min);
            REG_Y_MAX:  prdata = DATA_BITS'(cfg_reg.y_max);
            REG_WIDTH:  prdata = DATA_BITS'(cfg_reg.width);
            REG_HEIGHT: prdata = DATA_BITS'(cfg_reg.height);
            REG_MODE:   prdata = DATA_BITS'(cfg_reg.mode);
            default:    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: design/tpc_front.sv
// front end: touch detect, per-axis clamp and span classification
// depends on tpc_pkg
`default_nettype none

module tpc_front (
    input  wire logic [tpc_pkg::SAMPLE_BITS-1:0] raw_x,
    input  wire logic [tpc_pkg::SAMPLE_BITS-1:0] raw_y,
    input  wire logic [tpc_pkg::SAMPLE_BITS-1:0] raw_pressure,
    input  wire tpc_pkg::cfg_t                   cfg,
    output tpc_pkg::item_t                       item
);
    import tpc_pkg::*;

    logic [SAMPLE_BITS-1:0] off_x;
    logic [SAMPLE_BITS-1:0] off_y;
    logic [SAMPLE_BITS-1:0] span_x;
    logic [SAMPLE_BITS-1:0] span_y;
    logic                   eq_x;
    logic                   eq_y;

    // clamp then offset; inverted bounds give the full size (off = span = 1),
    // equal bounds give zero (off = 0, span = 1) so the divisor is never zero
    function automatic logic [2*SAMPLE_BITS:0] classify(
        input logic [SAMPLE_BITS-1:0] v,
        input logic [SAMPLE_BITS-1:0] lo,
        input logic [SAMPLE_BITS-1:0] hi
    );
        logic [SAMPLE_BITS-1:0] vc;
        logic [SAMPLE_BITS-1:0] off;
        logic [SAMPLE_BITS-1:0] span;
        logic                   eq;
        vc   = (v < lo) ? lo : ((v > hi) ? hi : v);
        eq   = (lo == hi);
        off  = vc - lo;
        span = hi - lo;
        if (lo > hi)
        begin
            off  = SAMPLE_BITS'(1);
            span = SAMPLE_BITS'(1);
        end
        else if (eq)
        begin
            off  = '0;
            span = SAMPLE_BITS'(1);
        end
        return {eq, off, span};
    endfunction

    assign {eq_x, off_x, span_x} = classify(raw_x, cfg.x_min, cfg.x_max);
    assign {eq_y, off_y, span_y} = classify(raw_y, cfg.y_min, cfg.y_max);

    always_comb
    begin
        item.touched  = (raw_pressure >= cfg.thresh);
        item.calib    = cfg.mode[MODE_CAL_BIT];
        item.rotate   = cfg.mode[MODE_ROT_BIT];
        item.err      = item.touched && item.calib && (eq_x || eq_y);
        item.pressure = raw_pressure;
        item.raw_x    = raw_x;
        item.raw_y    = raw_y;
        item.off_x    = off_x;
        item.off_y    = off_y;
        item.span_x   = span_x;
        item.span_y   = span_y;
    end

endmodule

`default_nettype wire

// File: design/tpc_queue.sv
// short fifo between the front end and the mapping pipeline
// depends on tpc_pkg
`default_nettype none

module tpc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tpc_pkg::item_t push_item,
    input  wire logic           pop,
    output tpc_pkg::item_t      head,
    output logic                full,
    output logic                empty
);
    import tpc_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    item_t               entries_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: design/tpc_back.sv
// back end: scale multiply, bit-per-stage restoring divide, rotate and format
// depends on tpc_pkg
`default_nettype none

module tpc_back (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    input  wire tpc_pkg::item_t                         in_item,
    input  wire tpc_pkg::cfg_t                          cfg,
    output logic                                        done,
    output logic signed [tpc_pkg::POINT_BITS-1:0]       point_x,
    output logic signed [tpc_pkg::POINT_BITS-1:0]       point_y,
    output logic        [tpc_pkg::PRESSURE_BITS-1:0]    pressure,
    output logic                                        range_error
);
    import tpc_pkg::*;

    localparam int NSTG = SCREEN_BITS;

    typedef struct packed {
        logic                   touched;
        logic                   calib;
        logic                   rotate;
        logic                   err;
        logic [SAMPLE_BITS-1:0] pressure;
        logic [SAMPLE_BITS-1:0] raw_x;
        logic [SAMPLE_BITS-1:0] raw_y;
        logic [SAMPLE_BITS-1:0] rem_x;
        logic [SAMPLE_BITS-1:0] rem_y;
        logic [SCREEN_BITS-1:0] low_x;
        logic [SCREEN_BITS-1:0] low_y;
        logic [SCREEN_BITS-1:0] quo_x;
        logic [SCREEN_BITS-1:0] quo_y;
        logic [SAMPLE_BITS-1:0] div_x;
        logic [SAMPLE_BITS-1:0] div_y;
    } pipe_t;

    pipe_t                  pipe_reg [NSTG+1];
    logic [NSTG:0]          vld_reg;
    logic [PROD_BITS-1:0]   prod_x;
    logic [PROD_BITS-1:0]   prod_y;
    pipe_t                  load;
    pipe_t                  last;
    logic                   done_reg;
    logic [POINT_BITS-1:0]  px_next;
    logic [POINT_BITS-1:0]  py_next;
    logic [POINT_BITS-1:0]  px_reg;
    logic [POINT_BITS-1:0]  py_reg;
    logic [PRESSURE_BITS-1:0] pz_next;
    logic [PRESSURE_BITS-1:0] pz_reg;
    logic                   err_next;
    logic                   err_reg;

    // one quotient bit: returns {bit, new remainder}
    function automatic logic [SAMPLE_BITS:0] div_bit(
        input logic [SAMPLE_BITS-1:0] rem,
        input logic                   nbit,
        input logic [SAMPLE_BITS-1:0] dvs
    );
        logic [SAMPLE_BITS:0] t;
        logic [SAMPLE_BITS:0] diff;
        t    = {rem, nbit};
        diff = t - {1'b0, dvs};
        if (t >= {1'b0, dvs})
        begin
            return {1'b1, diff[SAMPLE_BITS-1:0]};
        end
        return {1'b0, t[SAMPLE_BITS-1:0]};
    endfunction

    function automatic pipe_t div_step(input pipe_t p);
        pipe_t                n;
        logic [SAMPLE_BITS:0] rx;
        logic [SAMPLE_BITS:0] ry;
        n     = p;
        rx    = div_bit(p.rem_x, p.low_x[SCREEN_BITS-1], p.div_x);
        ry    = div_bit(p.rem_y, p.low_y[SCREEN_BITS-1], p.div_y);
        n.rem_x = rx[SAMPLE_BITS-1:0];
        n.rem_y = ry[SAMPLE_BITS-1:0];
        n.quo_x = {p.quo_x[SCREEN_BITS-2:0], rx[SAMPLE_BITS]};
        n.quo_y = {p.quo_y[SCREEN_BITS-2:0], ry[SAMPLE_BITS]};
        n.low_x = {p.low_x[SCREEN_BITS-2:0], 1'b0};
        n.low_y = {p.low_y[SCREEN_BITS-2:0], 1'b0};
        return n;
    endfunction

    function automatic logic [POINT_BITS-1:0] to_point(input logic [WIDE_BITS-1:0] v);
        return v[POINT_BITS-1:0];
    endfunction

    // scale by screen size; product stays below span << SCREEN_BITS
    assign prod_x = {{SCREEN_BITS{1'b0}}, in_item.off_x} * {{SAMPLE_BITS{1'b0}}, cfg.width};
    assign prod_y = {{SCREEN_BITS{1'b0}}, in_item.off_y} * {{SAMPLE_BITS{1'b0}}, cfg.height};

    always_comb
    begin
        load.touched  = in_item.touched;
        load.calib    = in_item.calib;
        load.rotate   = in_item.rotate;
        load.err      = in_item.err;
        load.pressure = in_item.pressure;
        load.raw_x    = in_item.raw_x;
        load.raw_y    = in_item.raw_y;
        load.rem_x    = prod_x[PROD_BITS-1:SCREEN_BITS];
        load.rem_y    = prod_y[PROD_BITS-1:SCREEN_BITS];
        load.low_x    = prod_x[SCREEN_BITS-1:0];
        load.low_y    = prod_y[SCREEN_BITS-1:0];
        load.quo_x    = '0;
        load.quo_y    = '0;
        load.div_x    = in_item.span_x;
        load.div_y    = in_item.span_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[NSTG-1:0], in_valid};
            done_reg <= vld_reg[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_reg[0] <= load;
        for (int k = 1; k <= NSTG; k++)
        begin
            pipe_reg[k] <= div_step(pipe_reg[k-1]);
        end
        px_reg  <= px_next;
        py_reg  <= py_next;
        pz_reg  <= pz_next;
        err_reg <= err_next;
    end

    assign last = pipe_reg[NSTG];

    always_comb
    begin
        px_next  = '0;
        py_next  = '0;
        pz_next  = '0;
        err_next = 1'b0;
        if (!last.touched)
        begin
            if (last.calib)
            begin
                px_next = '1;
                py_next = '1;
            end
        end
        else
        begin
            pz_next = last.pressure[PRESSURE_BITS-1:0];
            if (!last.calib)
            begin
                px_next = to_point(WIDE_BITS'(last.raw_x));
                py_next = to_point(WIDE_BITS'(last.raw_y));
            end
            else
            begin
                err_next = last.err;
                if (last.rotate)
                begin
                    px_next = to_point(WIDE_BITS'(last.quo_y));
                    py_next = to_point(WIDE_BITS'(cfg.width) - WIDE_BITS'(last.quo_x));
                end
                else
                begin
                    px_next = to_point(WIDE_BITS'(last.quo_x));
                    py_next = to_point(WIDE_BITS'(last.quo_y));
                end
            end
        end
    end

    assign done        = done_reg;
    assign point_x     = px_reg;
    assign point_y     = py_reg;
    assign pressure    = pz_reg;
    assign range_error = err_reg;

endmodule

`default_nettype wire

// File: design/touch_point_calibrate.sv
// touch_point_calibrate: an accepted start reaches the done strobe through its registers
// (SCREEN_BITS divider stages plus queue, multiply and output registers)
// one sample per cycle sustained; the divider is a bit-per-stage pipeline
// the result strobe lasts one cycle and cannot be held off by the receiver
// asynchronous active-low reset clears all control state and loads register defaults
`default_nettype none

module touch_point_calibrate (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // sample channel
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic        [tpc_pkg::SAMPLE_BITS-1:0] raw_x,
    input  wire logic        [tpc_pkg::SAMPLE_BITS-1:0] raw_y,
    input  wire logic        [tpc_pkg::SAMPLE_BITS-1:0] raw_pressure,
    // result channel
    output logic                                        done,
    output logic signed [tpc_pkg::POINT_BITS-1:0]       point_x,
    output logic signed [tpc_pkg::POINT_BITS-1:0]       point_y,
    output logic        [tpc_pkg::PRESSURE_BITS-1:0]    pressure,
    output logic                                        range_error,
    // configuration port
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic        [tpc_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic        [tpc_pkg::DATA_BITS-1:0]   pwdata,
    output logic             [tpc_pkg::DATA_BITS-1:0]   prdata,
    output logic                                        pready
);
    import tpc_pkg::*;

    cfg_t  cfg;
    item_t front_item;
    item_t head_item;
    logic  q_full;
    logic  q_empty;
    logic  accept;

    // register file; writes complete in the access beat, no wait states
    assign pready = 1'b1;

    tpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // front end classifies the sample in the accept cycle
    tpc_front u_front (
        .raw_x        (raw_x),
        .raw_y        (raw_y),
        .raw_pressure (raw_pressure),
        .cfg          (cfg),
        .item         (front_item)
    );

    // busy only reflects a full queue; the back end drains one beat per cycle
    assign busy   = q_full;
    assign accept = start && !busy;

    tpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .pop       (!q_empty),
        .head      (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back end never stalls: multiply, divider stages, output register
    tpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (!q_empty),
        .in_item     (head_item),
        .cfg         (cfg),
        .done        (done),
        .point_x     (point_x),
        .point_y     (point_y),
        .pressure    (pressure),
        .range_error (range_error)
    );

    // every accepted beat produces a result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted beat produced no result");

    // no result without a matching accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without an accepted beat");

    // an axis error is only reported for calibrated touches
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && range_error) |-> (cfg.mode[MODE_CAL_BIT] && (pressure >= cfg.thresh)))
        else $error("range error outside a calibrated touch");

endmodule

`default_nettype wire
